FILE: sv/radio_sample_frame_repacker_macros.svh
// assertion macros for the frame repacker checker
`ifndef RADIO_SAMPLE_FRAME_REPACKER_MACROS_SVH
`define RADIO_SAMPLE_FRAME_REPACKER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RSFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsfr check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define RSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsfr check failed");

`endif

FILE: sv/rsfr_pkg.sv
package rsfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 5;
  localparam int unsigned PairN    = 5;
  localparam int unsigned PairAw   = 3;
  localparam int unsigned StepW    = 3;

  localparam logic [ByteW-1:0] FrameDelim  = 8'h7E;
  localparam logic [ByteW-1:0] EndByte     = 8'hFF;
  localparam logic [ByteW-1:0] HeaderReset = 8'h80;

  localparam logic [PosW-1:0] PosStart       = 5'd0;
  localparam logic [PosW-1:0] PosSumFirst    = 5'd3;
  localparam logic [PosW-1:0] PosSampleFirst = 5'd11;
  localparam logic [PosW-1:0] PosSampleLast  = 5'd20;
  localparam logic [PosW-1:0] PosCheck       = 5'd21;
  localparam logic [PosW-1:0] PosDone        = 5'd22;

  localparam logic [StepW-1:0] StepHeader    = 3'd0;
  localparam logic [StepW-1:0] StepLastPair  = 3'd5;
  localparam logic [StepW-1:0] StepEnd       = 3'd6;

  typedef struct packed {
    logic              we_hi;
    logic              we_lo;
    logic [PairAw-1:0] addr;
    logic [ByteW-1:0]  data;
  } mem_wr_t;

  function automatic logic [ByteW-1:0] repack(input logic [2*ByteW-1:0] pair);
    repack = {pair[ByteW+2:ByteW], pair[ByteW-1:3]};
  endfunction

endpackage

FILE: sv/rsfr_sample_mem.sv
module rsfr_sample_mem (
  input  logic                                 clk_i,
  input  rsfr_pkg::mem_wr_t                    wr_i,
  input  logic [rsfr_pkg::PairAw-1:0]          rd_addr_i,
  output logic [2*rsfr_pkg::ByteW-1:0]         rd_data_o
);

  logic [2*rsfr_pkg::ByteW-1:0] mem_q [rsfr_pkg::PairN];
  logic [2*rsfr_pkg::ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_hi) begin
      mem_q[wr_i.addr][2*rsfr_pkg::ByteW-1:rsfr_pkg::ByteW] <= wr_i.data;
    end
    if (wr_i.we_lo) begin
      mem_q[wr_i.addr][rsfr_pkg::ByteW-1:0] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/rsfr_parser.sv
module rsfr_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rx_valid_i,
  input  logic [rsfr_pkg::ByteW-1:0]  rx_byte_i,
  output logic                        rx_stall_o,
  input  logic                        busy_i,
  output rsfr_pkg::mem_wr_t           wr_o,
  output logic                        match_o
);

  logic [rsfr_pkg::PosW-1:0]  pos_q, pos_d;
  logic [rsfr_pkg::ByteW-1:0] sum_q, sum_d;
  logic [rsfr_pkg::PosW-1:0]  eff_pos;
  logic [rsfr_pkg::PosW-1:0]  offset;
  logic                       in_samples;
  logic                       accept;
  logic                       live;

  assign eff_pos    = (rx_byte_i == rsfr_pkg::FrameDelim) ? rsfr_pkg::PosStart : pos_q;
  assign in_samples = (eff_pos >= rsfr_pkg::PosSampleFirst) &&
                      (eff_pos <= rsfr_pkg::PosSampleLast);
  // hold sample writes while a message still reads the store
  assign rx_stall_o = busy_i && in_samples;
  assign accept     = rx_valid_i && !rx_stall_o;
  assign live       = eff_pos < rsfr_pkg::PosDone;
  assign offset     = eff_pos - rsfr_pkg::PosSampleFirst;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (accept) begin
      if (live) begin
        pos_d = eff_pos + 5'd1;
      end else begin
        pos_d = eff_pos;
      end
      if (eff_pos == rsfr_pkg::PosStart) begin
        sum_d = '0;
      end else if ((eff_pos >= rsfr_pkg::PosSumFirst) && (eff_pos < rsfr_pkg::PosCheck)) begin
        sum_d = sum_q + rx_byte_i;
      end
    end
  end

  always_comb begin
    wr_o.we_hi = accept && in_samples && !offset[0];
    wr_o.we_lo = accept && in_samples && offset[0];
    wr_o.addr  = offset[rsfr_pkg::PairAw:1];
    wr_o.data  = rx_byte_i;
  end

  assign match_o = accept && (eff_pos == rsfr_pkg::PosCheck) &&
                   (rx_byte_i == (rsfr_pkg::EndByte - sum_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

endmodule

FILE: sv/rsfr_emitter.sv
module rsfr_emitter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 match_i,
  input  logic [rsfr_pkg::ByteW-1:0]           header_code_i,
  input  logic [2*rsfr_pkg::ByteW-1:0]         rd_data_i,
  output logic [rsfr_pkg::PairAw-1:0]          rd_addr_o,
  output logic                                 busy_o,
  output logic                                 tx_valid_o,
  input  logic                                 tx_stall_i,
  output logic [rsfr_pkg::ByteW-1:0]           tx_byte_o,
  output logic                                 tx_end_of_message_o
);

  logic [rsfr_pkg::StepW-1:0] step_q, step_d;
  logic                       busy_q, busy_d;
  logic                       valid_q, valid_d;
  logic [rsfr_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       eom_q, eom_d;
  logic                       load;
  logic [rsfr_pkg::StepW-1:0] pair_idx;

  assign load = busy_q && (!valid_q || !tx_stall_i);

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (match_i) begin
      busy_d = 1'b1;
      step_d = rsfr_pkg::StepHeader;
    end else if (load) begin
      if (step_q == rsfr_pkg::StepEnd) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  // prefetch the pair that the next word needs
  assign pair_idx  = step_d - 3'd1;
  assign rd_addr_o = ((step_d == rsfr_pkg::StepHeader) || (step_d > rsfr_pkg::StepLastPair)) ?
                     '0 : pair_idx;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    eom_d   = eom_q;
    if (load) begin
      valid_d = 1'b1;
      eom_d   = 1'b0;
      case (step_q)
        rsfr_pkg::StepHeader: byte_d = header_code_i;
        rsfr_pkg::StepEnd: begin
          byte_d = rsfr_pkg::EndByte;
          eom_d  = 1'b1;
        end
        default: byte_d = rsfr_pkg::repack(rd_data_i);
      endcase
    end else if (!tx_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eom_q  <= eom_d;
  end

  assign busy_o              = busy_q;
  assign tx_valid_o          = valid_q;
  assign tx_byte_o           = byte_q;
  assign tx_end_of_message_o = eom_q;

endmodule

FILE: sv/radio_sample_frame_repacker.sv
// channel  | direction | handshake                 | payload
// rx       | in        | rx_valid_i / rx_stall_o   | rx_byte_i
// tx       | out       | tx_valid_o / tx_stall_i   | tx_byte_o, tx_end_of_message_o
// cfg      | in        | cfg_we_i                  | cfg_wdata_i (header code)
//
// one received byte per cycle while rx is not stalled; a good checksum byte queues a seven-word message
// message words leave one per cycle from an output register while tx_stall_i is low, samples read from
// the registered pair memory at the address of the upcoming step
// rx stalls only for a sample byte arriving while the emitter is still busy with a message
// reset clears position, sum, message sequencer and output valid; header returns to 0x80
module radio_sample_frame_repacker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       tx_valid_o,
  input  logic       tx_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_end_of_message_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [rsfr_pkg::ByteW-1:0]   header_q;
  rsfr_pkg::mem_wr_t            wr;
  logic                         match;
  logic                         busy;
  logic [rsfr_pkg::PairAw-1:0]  rd_addr;
  logic [2*rsfr_pkg::ByteW-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= rsfr_pkg::HeaderReset;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  rsfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .rx_stall_o (rx_stall_o),
    .busy_i     (busy),
    .wr_o       (wr),
    .match_o    (match)
  );

  rsfr_sample_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rsfr_emitter u_emitter (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .match_i             (match),
    .header_code_i       (header_q),
    .rd_data_i           (rd_data),
    .rd_addr_o           (rd_addr),
    .busy_o              (busy),
    .tx_valid_o          (tx_valid_o),
    .tx_stall_i          (tx_stall_i),
    .tx_byte_o           (tx_byte_o),
    .tx_end_of_message_o (tx_end_of_message_o)
  );

endmodule

FILE: sv/rsfr_checker.sv
`include "radio_sample_frame_repacker_macros.svh"

module rsfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       tx_valid_o,
  input logic       tx_stall_i,
  input logic [7:0] tx_byte_o,
  input logic       tx_end_of_message_o
);

  logic eom_taken;

  assign eom_taken = tx_valid_o && !tx_stall_i && tx_end_of_message_o;

  `RSFR_ASSERT_NOW(a_eom_is_end_byte, tx_valid_o && tx_end_of_message_o, tx_byte_o == 8'hFF)
  `RSFR_ASSERT_NEXT(a_tx_hold, tx_valid_o && tx_stall_i, tx_valid_o && $stable(tx_byte_o))
  `RSFR_ASSERT_NEXT(a_no_double_eom, eom_taken, !(tx_valid_o && tx_end_of_message_o))
  `RSFR_ASSERT_NOW(a_delim_never_stalls, rx_valid_i && (rx_byte_i == 8'h7E), !rx_stall_o)

endmodule

bind radio_sample_frame_repacker rsfr_checker u_rsfr_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .rx_valid_i          (rx_valid_i),
  .rx_stall_o          (rx_stall_o),
  .rx_byte_i           (rx_byte_i),
  .tx_valid_o          (tx_valid_o),
  .tx_stall_i          (tx_stall_i),
  .tx_byte_o           (tx_byte_o),
  .tx_end_of_message_o (tx_end_of_message_o)
);

FILE: dv/radio_sample_frame_repacker_tb.sv
module radio_sample_frame_repacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 4;
  localparam int ResetCycles = 11;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 3000;
  localparam int SettleCycles = 12;
  localparam int SampleN = 2 * rsfr_pkg::PairN;

  typedef logic [7:0] rx_bytes_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } msg_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic       tx_valid_o;
  logic       tx_stall_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic       tx_end_of_message_o;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  // predictor state
  logic [4:0] frame_pos = rsfr_pkg::PosStart;
  logic [7:0] frame_sum = '0;
  logic [7:0] sample_mem[SampleN];
  logic [7:0] hdr_code = rsfr_pkg::HeaderReset;
  msg_word_t  msg_words_q[$];

  int src_idle_pct = 33;
  int sink_idle_pct = 46;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int err_cnt = 0;

  radio_sample_frame_repacker DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rx_valid_i         (rx_valid_i),
    .rx_stall_o         (rx_stall_o),
    .rx_byte_i          (rx_byte_i),
    .tx_valid_o         (tx_valid_o),
    .tx_stall_i         (tx_stall_i),
    .tx_byte_o          (tx_byte_o),
    .tx_end_of_message_o(tx_end_of_message_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void parse_rx_word(input logic [7:0] b);
    logic [4:0] pos;
    logic [7:0] want;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] v;
    if (b == rsfr_pkg::FrameDelim) frame_pos = rsfr_pkg::PosStart;
    pos = frame_pos;
    if (pos < rsfr_pkg::PosDone) begin
      if (pos == rsfr_pkg::PosStart) frame_sum = '0;
      if (pos >= rsfr_pkg::PosSumFirst && pos < rsfr_pkg::PosCheck) frame_sum = frame_sum + b;
      if (pos >= rsfr_pkg::PosSampleFirst && pos < rsfr_pkg::PosCheck) begin
        sample_mem[pos - rsfr_pkg::PosSampleFirst] = b;
      end
      want = rsfr_pkg::EndByte - frame_sum;
      if (pos == rsfr_pkg::PosCheck && b == want) begin
        msg_words_q.push_back('{hdr_code, 1'b0});
        for (int i = 0; i < rsfr_pkg::PairN; i++) begin
          hi = sample_mem[2 * i];
          lo = sample_mem[2 * i + 1];
          v = (hi << 5) | (lo >> 3);
          msg_words_q.push_back('{v, 1'b0});
        end
        msg_words_q.push_back('{rsfr_pkg::EndByte, 1'b1});
      end
      frame_pos = pos + 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    msg_word_t exp_w;
    if (rst_ni) begin
      if (rx_valid_i && !rx_stall_o) parse_rx_word(rx_byte_i);
      if (tx_valid_o && !tx_stall_i) begin
        if (msg_words_q.size() == 0) begin
          $error("unexpected word: tx_byte %02h end_of_message %0b",
                 tx_byte_o, tx_end_of_message_o);
          err_cnt++;
        end else begin
          exp_w = msg_words_q.pop_front();
          if (tx_byte_o !== exp_w.data) begin
            $error("tx_byte: expected %02h, actual %02h", exp_w.data, tx_byte_o);
            err_cnt++;
          end
          if (tx_end_of_message_o !== exp_w.eom) begin
            $error("end_of_message: expected %0b, actual %0b",
                   exp_w.eom, tx_end_of_message_o);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      tx_stall_i <= 1'b1;
    end else begin
      tx_stall_i <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((rx_valid_i && !rx_stall_o) || (tx_valid_o && !tx_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("radio_sample_frame_repacker verification failed");
      $finish;
    end
  end

  task automatic send_rx_word(input logic [7:0] b);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      rx_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (rx_stall_o);
  endtask

  task automatic send_rx_words(input rx_bytes_t f);
    foreach (f[i]) send_rx_word(f[i]);
  endtask

  task automatic wait_drained();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (msg_words_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] v);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_code = v;
  endtask

  function automatic logic [7:0] rand_data();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == rsfr_pkg::FrameDelim);
    return v;
  endfunction

  // fill < 0 gives random samples, else every sample byte is fill
  function automatic rx_bytes_t make_frame(input bit lead_delim, input int fill);
    rx_bytes_t f;
    logic [7:0] s;
    logic [7:0] ck;
    do begin
      f = {};
      s = '0;
      f.push_back(lead_delim ? rsfr_pkg::FrameDelim : rand_data());
      for (int p = 1; p < rsfr_pkg::PosCheck; p++) begin
        if (fill >= 0 && p >= rsfr_pkg::PosSampleFirst) f.push_back(fill[7:0]);
        else f.push_back(rand_data());
        if (p >= rsfr_pkg::PosSumFirst) s = s + f[p];
      end
      ck = rsfr_pkg::EndByte - s;
    end while (ck == rsfr_pkg::FrameDelim);
    f.push_back(ck);
    return f;
  endfunction

  function automatic rx_bytes_t make_bad_frame();
    rx_bytes_t f;
    logic [7:0] ck;
    f = make_frame(1'b1, -1);
    do ck = f[rsfr_pkg::PosCheck] ^ 8'($urandom_range(1, 255));
    while (ck == rsfr_pkg::FrameDelim);
    f[rsfr_pkg::PosCheck] = ck;
    return f;
  endfunction

  task automatic test_stream_start();
    send_rx_words(make_frame(1'b0, -1));
    send_rx_words(make_frame(1'b1, -1));
  endtask

  task automatic test_sample_extremes();
    write_header(8'hFF);
    send_rx_words(make_frame(1'b1, 0));
    send_rx_words(make_frame(1'b1, 255));
    write_header(8'h00);
    send_rx_words(make_frame(1'b1, 255));
    send_rx_words(make_frame(1'b1, 0));
  endtask

  task automatic test_delimiter_restart();
    rx_bytes_t f;
    logic [7:0] s;
    f = make_frame(1'b1, -1);
    f[$urandom_range(rsfr_pkg::PosSampleFirst, rsfr_pkg::PosSampleLast)] = rsfr_pkg::FrameDelim;
    send_rx_words(f);
    send_rx_words(make_frame(1'b1, -1));
    // delimiter lands exactly where the checksum would match
    do begin
      f = make_frame(1'b1, -1);
      s = '0;
      for (int p = rsfr_pkg::PosSumFirst + 1; p < rsfr_pkg::PosCheck; p++) s = s + f[p];
      f[rsfr_pkg::PosSumFirst] = rsfr_pkg::EndByte - rsfr_pkg::FrameDelim - s;
    end while (f[rsfr_pkg::PosSumFirst] == rsfr_pkg::FrameDelim);
    f[rsfr_pkg::PosCheck] = rsfr_pkg::FrameDelim;
    send_rx_words(f);
    send_rx_words(make_frame(1'b1, -1));
  endtask

  task automatic test_bad_checksum();
    send_rx_words(make_bad_frame());
    send_rx_words(make_frame(1'b1, -1));
  endtask

  task automatic test_trailing_bytes();
    rx_bytes_t f;
    f = make_frame(1'b1, -1);
    send_rx_words(f);
    send_rx_word(f[rsfr_pkg::PosCheck]);
    repeat (4) send_rx_word(rand_data());
    send_rx_words(make_frame(1'b1, -1));
  endtask

  task automatic test_backpressure();
    write_header(8'h81);
    hold_req++;
    repeat (3) send_rx_words(make_frame(1'b1, -1));
    wait_drained();
    send_rx_words(make_frame(1'b1, -1));
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int kind;
    rx_bytes_t f;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        f = make_frame(1'b1, -1);
      end else if (kind < 78) begin
        f = make_bad_frame();
      end else if (kind < 86) begin
        f = make_frame(1'b1, -1);
        f = f[0:$urandom_range(0, rsfr_pkg::PosCheck - 1)];
      end else if (kind < 92) begin
        f = make_frame(1'b1, -1);
        f[$urandom_range(1, rsfr_pkg::PosCheck)] = rsfr_pkg::FrameDelim;
      end else if (kind < 96) begin
        f = make_frame(1'b1, -1);
        send_rx_words(f);
        sent += f.size();
        f = {};
        repeat ($urandom_range(1, 6)) f.push_back(rand_data());
      end else begin
        f = {};
        repeat ($urandom_range(1, 8)) f.push_back(8'($urandom_range(0, 255)));
      end
      send_rx_words(f);
      sent += f.size();
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stream_start();
    test_sample_extremes();
    test_delimiter_restart();
    test_bad_checksum();
    test_trailing_bytes();
    test_backpressure();

    write_header(8'($urandom_range(0, 255)));
    test_random(24);

    write_header(8'h80);
    src_idle_pct = 46;
    sink_idle_pct = 33;
    test_random(24);

    write_header(8'($urandom_range(0, 255)));
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(24);

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (msg_words_q.size() != 0) begin
      $error("%0d expected words never arrived", msg_words_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("radio_sample_frame_repacker verification clean");
    end else begin
      $display("radio_sample_frame_repacker verification failed");
    end
    $finish;
  end

endmodule
